// ===== rtl/grid_detection_box_decode_top_assert.svh =====
// Assertion macros for the grid box decode checker.
// Uses clk and rst_n of the scope that expands them.
`ifndef GRID_DETECTION_BOX_DECODE_TOP_ASSERT_SVH
`define GRID_DETECTION_BOX_DECODE_TOP_ASSERT_SVH

// clocked assertion, quiet while reset is held
`define GDBD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gdbd assertion failed");

// clocked assertion that also holds during reset
`define GDBD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gdbd assertion failed");

`endif

// ===== rtl/gdbd_pkg.sv =====
// Shared types, constants and register codes of the grid box decode.
// No dependencies.
`default_nettype none
package gdbd_pkg;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int CLASS_COUNT = 4;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [15:0] RST_CONF_THR = 16'd26214;
  localparam logic [6:0]  RST_STRIDE_H = 7'd16;
  localparam logic [6:0]  RST_STRIDE_V = 7'd16;
  localparam logic [15:0] RST_GAIN_H   = 16'd8960;
  localparam logic [15:0] RST_GAIN_V   = 16'd8960;
  localparam logic [9:0]  RST_MAX_COL  = 10'd959;
  localparam logic [9:0]  RST_MAX_ROW  = 10'd543;

  // 4.0 pixels in Q.8
  localparam logic signed [18:0] MIN_SIZE_Q8 = 19'sd1024;

  typedef enum logic [2:0] {
    REG_CONF_THR = 3'd0,
    REG_STRIDE_H = 3'd1,
    REG_STRIDE_V = 3'd2,
    REG_GAIN_H   = 3'd3,
    REG_GAIN_V   = 3'd4,
    REG_MAX_COL  = 3'd5,
    REG_MAX_ROW  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] conf_thr;
    logic [6:0]  stride_h;
    logic [6:0]  stride_v;
    logic [15:0] gain_h;
    logic [15:0] gain_v;
    logic [9:0]  max_col;
    logic [9:0]  max_row;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;
    logic [1:0]         class_index;
    logic [15:0]        score;
    logic signed [15:0] left_offset;
    logic signed [15:0] top_offset;
    logic signed [15:0] right_offset;
    logic signed [15:0] bottom_offset;
  } cell_t;

  typedef struct packed {
    logic [9:0]  box_left;
    logic [9:0]  box_top;
    logic [9:0]  box_width;
    logic [9:0]  box_height;
    logic [15:0] box_score;
    logic [1:0]  box_class;
  } box_t;

endpackage
`default_nettype wire

// ===== rtl/gdbd_cell_if.sv =====
// Input channel: one detector grid cell per item.
// Depends on nothing.
`default_nettype none
interface gdbd_cell_if;
  logic               valid;
  logic               ready;
  logic [5:0]         cell_col;
  logic [5:0]         cell_row;
  logic [1:0]         class_index;
  logic [15:0]        score;
  logic signed [15:0] left_offset;
  logic signed [15:0] top_offset;
  logic signed [15:0] right_offset;
  logic signed [15:0] bottom_offset;

  modport source (output valid, cell_col, cell_row, class_index, score,
                  left_offset, top_offset, right_offset, bottom_offset,
                  input ready);
  modport sink (input valid, cell_col, cell_row, class_index, score,
                left_offset, top_offset, right_offset, bottom_offset,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/gdbd_box_if.sv =====
// Result channel: one decoded box per item.
// Depends on nothing.
`default_nettype none
interface gdbd_box_if;
  logic        valid;
  logic        ready;
  logic [9:0]  box_left;
  logic [9:0]  box_top;
  logic [9:0]  box_width;
  logic [9:0]  box_height;
  logic [15:0] box_score;
  logic [1:0]  box_class;

  modport source (output valid, box_left, box_top, box_width, box_height,
                  box_score, box_class, input ready);
  modport sink (input valid, box_left, box_top, box_width, box_height,
                box_score, box_class, output ready);
endinterface
`default_nettype wire

// ===== rtl/grid_detection_box_decode_top.sv =====
// Grid box decode top level: input register, decode logic, result register.
// Path: an accepted item is registered in the input register, then in the result register (two register stages).
// Throughput: one item per cycle; a kept cell stalls the input while an untaken box waits.
// Cells that fail threshold, range or size checks leave no result.
// Reset: synchronous active-low rst_n clears the pipe and loads register defaults.
// Depends on gdbd_pkg, gdbd_cell_if, gdbd_box_if, gdbd_cfg, gdbd_core.
`default_nettype none
module grid_detection_box_decode_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  gdbd_cell_if.sink                         in_chan,
  gdbd_box_if.source                        out_chan,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gdbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gdbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [gdbd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import gdbd_pkg::*;

  cfg_t  cfg;
  cell_t in_cell;
  cell_t s1_cell_r;
  logic  s1_valid_r, s1_valid_nxt;
  box_t  core_box;
  logic  core_keep;
  box_t  out_box_r;
  logic  out_valid_r, out_valid_nxt;
  logic  out_load, s1_adv, in_rdy;

  gdbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gdbd_core u_core (
    .grid_in (s1_cell_r),
    .cfg     (cfg),
    .keep    (core_keep),
    .box     (core_box)
  );

  assign in_cell.cell_col      = in_chan.cell_col;
  assign in_cell.cell_row      = in_chan.cell_row;
  assign in_cell.class_index   = in_chan.class_index;
  assign in_cell.score         = in_chan.score;
  assign in_cell.left_offset   = in_chan.left_offset;
  assign in_cell.top_offset    = in_chan.top_offset;
  assign in_cell.right_offset  = in_chan.right_offset;
  assign in_cell.bottom_offset = in_chan.bottom_offset;

  assign out_load = !out_valid_r || out_chan.ready;
  // a dropped cell never needs the output register
  assign s1_adv   = s1_valid_r && (out_load || !core_keep);
  assign in_rdy   = !s1_valid_r || s1_adv;
  assign in_chan.ready = in_rdy;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_rdy)
      s1_valid_nxt = in_chan.valid;
    out_valid_nxt = out_valid_r;
    if (out_load)
      out_valid_nxt = s1_valid_r && core_keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_chan.valid)
      s1_cell_r <= in_cell;
    if (out_load && s1_valid_r && core_keep)
      out_box_r <= core_box;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.box_left   = out_box_r.box_left;
  assign out_chan.box_top    = out_box_r.box_top;
  assign out_chan.box_width  = out_box_r.box_width;
  assign out_chan.box_height = out_box_r.box_height;
  assign out_chan.box_score  = out_box_r.box_score;
  assign out_chan.box_class  = out_box_r.box_class;

endmodule
`default_nettype wire

// ===== rtl/gdbd_cfg.sv =====
// APB-style configuration register bank of the grid box decode.
// Depends on gdbd_pkg.
`default_nettype none
module gdbd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gdbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gdbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [gdbd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output gdbd_pkg::cfg_t                    cfg
);
  import gdbd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_CONF_THR: cfg_nxt.conf_thr = pwdata[15:0];
        REG_STRIDE_H: cfg_nxt.stride_h = pwdata[6:0];
        REG_STRIDE_V: cfg_nxt.stride_v = pwdata[6:0];
        REG_GAIN_H:   cfg_nxt.gain_h   = pwdata[15:0];
        REG_GAIN_V:   cfg_nxt.gain_v   = pwdata[15:0];
        REG_MAX_COL:  cfg_nxt.max_col  = pwdata[9:0];
        REG_MAX_ROW:  cfg_nxt.max_row  = pwdata[9:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CONF_THR: prdata = {16'd0, cfg_r.conf_thr};
      REG_STRIDE_H: prdata = {25'd0, cfg_r.stride_h};
      REG_STRIDE_V: prdata = {25'd0, cfg_r.stride_v};
      REG_GAIN_H:   prdata = {16'd0, cfg_r.gain_h};
      REG_GAIN_V:   prdata = {16'd0, cfg_r.gain_v};
      REG_MAX_COL:  prdata = {22'd0, cfg_r.max_col};
      REG_MAX_ROW:  prdata = {22'd0, cfg_r.max_row};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_thr <= RST_CONF_THR;
      cfg_r.stride_h <= RST_STRIDE_H;
      cfg_r.stride_v <= RST_STRIDE_V;
      cfg_r.gain_h   <= RST_GAIN_H;
      cfg_r.gain_v   <= RST_GAIN_V;
      cfg_r.max_col  <= RST_MAX_COL;
      cfg_r.max_row  <= RST_MAX_ROW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gdbd_core.sv =====
// Combinational box decode of one registered cell: centre, scaled edges,
// clamping and size test. Depends on gdbd_pkg.
`default_nettype none
module gdbd_core (
  input  wire gdbd_pkg::cell_t grid_in,
  input  wire gdbd_pkg::cfg_t  cfg,
  output logic                 keep,
  output gdbd_pkg::box_t       box
);
  import gdbd_pkg::*;

  // offset (Q4.12) * gain (Q8.8) -> Q.20, floor to Q.8
  function automatic logic signed [20:0] scale_off(input logic signed [15:0] off,
                                                   input logic [15:0] gain);
    logic signed [32:0] prod;
    prod = off * $signed({1'b0, gain});
    return prod[32:12];
  endfunction

  function automatic logic [17:0] clamp_edge(input logic signed [22:0] e,
                                             input logic [9:0] mx);
    logic signed [22:0] hi;
    hi = $signed({5'd0, mx, 8'd0});
    if (e < 23'sd0)
      return '0;
    else if (e > hi)
      return {mx, 8'd0};
    else
      return e[17:0];
  endfunction

  logic [12:0]        px, py;
  logic [20:0]        cx, cy;
  logic signed [20:0] dl, dt, dr, db;
  logic signed [22:0] el, et, er, eb;
  logic [17:0]        x1, y1, x2, y2;
  logic signed [18:0] w, h;
  logic               in_range, above_thr;

  assign px = 13'(grid_in.cell_col) * 13'(cfg.stride_h);
  assign py = 13'(grid_in.cell_row) * 13'(cfg.stride_v);
  assign cx = {px, 8'h80};
  assign cy = {py, 8'h80};

  assign dl = scale_off(grid_in.left_offset,   cfg.gain_h);
  assign dt = scale_off(grid_in.top_offset,    cfg.gain_v);
  assign dr = scale_off(grid_in.right_offset,  cfg.gain_h);
  assign db = scale_off(grid_in.bottom_offset, cfg.gain_v);

  assign el = $signed({2'b00, cx}) - {{2{dl[20]}}, dl};
  assign et = $signed({2'b00, cy}) - {{2{dt[20]}}, dt};
  assign er = $signed({2'b00, cx}) + {{2{dr[20]}}, dr};
  assign eb = $signed({2'b00, cy}) + {{2{db[20]}}, db};

  assign x1 = clamp_edge(el, cfg.max_col);
  assign y1 = clamp_edge(et, cfg.max_row);
  assign x2 = clamp_edge(er, cfg.max_col);
  assign y2 = clamp_edge(eb, cfg.max_row);

  assign w = $signed({1'b0, x2}) - $signed({1'b0, x1});
  assign h = $signed({1'b0, y2}) - $signed({1'b0, y1});

  assign in_range = ({3'd0, grid_in.cell_col} < 9'(GRID_COLS)) &&
                    ({3'd0, grid_in.cell_row} < 9'(GRID_ROWS)) &&
                    ({3'd0, grid_in.class_index} < 5'(CLASS_COUNT));
  assign above_thr = grid_in.score >= cfg.conf_thr;

  assign keep = in_range && above_thr && (w > MIN_SIZE_Q8) && (h > MIN_SIZE_Q8);

  assign box.box_left   = x1[17:8];
  assign box.box_top    = y1[17:8];
  assign box.box_width  = w[17:8];
  assign box.box_height = h[17:8];
  assign box.box_score  = grid_in.score;
  assign box.box_class  = grid_in.class_index;

endmodule
`default_nettype wire

// ===== rtl/gdbd_checker.sv =====
// Port-level checker for the grid box decode, with its bind to the top level.
// Depends on grid_detection_box_decode_top_assert.svh.
`default_nettype none
`include "grid_detection_box_decode_top_assert.svh"
module gdbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [9:0]  box_left,
  input wire logic [9:0]  box_top,
  input wire logic [9:0]  box_width,
  input wire logic [9:0]  box_height,
  input wire logic [15:0] box_score,
  input wire logic [1:0]  box_class
);

  // pipe empty straight after reset
  `GDBD_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid)

  `GDBD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({box_left, box_top, box_width, box_height, box_score, box_class}))

  // only boxes at least four pixels wide and tall leave
  `GDBD_ASSERT(a_min_size, out_valid |-> box_width >= 10'd4 && box_height >= 10'd4)

  // clamped box stays within the coordinate range
  `GDBD_ASSERT(a_in_frame, out_valid |-> ({1'b0, box_left} + {1'b0, box_width}) <= 11'd1023 && ({1'b0, box_top} + {1'b0, box_height}) <= 11'd1023)

endmodule

bind grid_detection_box_decode_top gdbd_checker u_gdbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .box_left   (out_chan.box_left),
  .box_top    (out_chan.box_top),
  .box_width  (out_chan.box_width),
  .box_height (out_chan.box_height),
  .box_score  (out_chan.box_score),
  .box_class  (out_chan.box_class)
);
`default_nettype wire
